@@ sv/lli_pkg.sv @@
// Shared types and constants for the line intersection pipeline.
// No dependencies; every other file imports this package.
package lli_pkg;

    localparam int COORD_WIDTH = 16;
    // Width of one coordinate difference.
    localparam int DIFF_W = COORD_WIDTH + 1;
    // Width of one product of two differences.
    localparam int PROD_W = 2 * COORD_WIDTH + 2;
    // Width of the numerator and denominator cross products.
    localparam int CROSS_W = 2 * COORD_WIDTH + 3;
    // Width of the numerator times a line direction.
    localparam int DIVIDEND_W = 3 * COORD_WIDTH + 4;
    // Quotient bits kept. Larger quotients always saturate.
    localparam int QUOT_W = COORD_WIDTH + 2;
    // Width of the final sum of base and quotient.
    localparam int SUM_W = COORD_WIDTH + 4;
    // Stage counts of the front end and the divider.
    localparam int FRONT_LAT = 5;
    localparam int DIV_LAT = QUOT_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord first_start_x;
        t_coord first_start_y;
        t_coord first_end_x;
        t_coord first_end_y;
        t_coord second_start_x;
        t_coord second_start_y;
        t_coord second_end_x;
        t_coord second_end_y;
    } t_in;

    typedef struct packed {
        logic   found;
        t_coord cross_x;
        t_coord cross_y;
        logic   clipped;
    } t_out;

    // Front end result: magnitudes for the two divider lanes plus sideband.
    typedef struct packed {
        logic [DIVIDEND_W-1:0] mag_x;
        logic [DIVIDEND_W-1:0] mag_y;
        logic [CROSS_W-1:0]    mag_den;
        logic                  neg_x;
        logic                  neg_y;
        logic                  den_zero;
        t_coord                base_x;
        t_coord                base_y;
    } t_front;

    // Sideband that rides alongside the divider lanes.
    typedef struct packed {
        logic   neg_x;
        logic   neg_y;
        logic   den_zero;
        t_coord base_x;
        t_coord base_y;
    } t_side;

endpackage

@@ sv/lli_front.sv @@
// Front end of the intersection pipeline: differences, cross products,
// scaled numerators and magnitudes in five register stages. Uses lli_pkg.
module lli_front (
    input  logic          i_clk,
    input  logic          i_en,
    input  lli_pkg::t_in  i_data,
    output lli_pkg::t_front o_data
);
    import lli_pkg::*;

    // Stage 1: coordinate differences.
    logic signed [DIFF_W-1:0] r_d13x, r_d13y, r_d12x, r_d12y, r_d34x, r_d34y;
    logic signed [DIFF_W-1:0] r1_dx21, r1_dy21;
    t_coord r1_bx, r1_by;
    // Stage 2: the four products.
    logic signed [PROD_W-1:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [DIFF_W-1:0] r2_dx21, r2_dy21;
    t_coord r2_bx, r2_by;
    // Stage 3: numerator and denominator.
    logic signed [CROSS_W-1:0] r_num, r3_den;
    logic signed [DIFF_W-1:0] r3_dx21, r3_dy21;
    t_coord r3_bx, r3_by;
    // Stage 4: numerator scaled by each direction.
    logic signed [DIVIDEND_W-1:0] r_px, r_py;
    logic signed [CROSS_W-1:0] r4_den;
    t_coord r4_bx, r4_by;
    // Stage 5: magnitudes and signs.
    t_front r_out;

    function automatic logic signed [DIFF_W-1:0] sub_ext(input t_coord a, input t_coord b);
        sub_ext = DIFF_W'({a[COORD_WIDTH-1], a}) - DIFF_W'({b[COORD_WIDTH-1], b});
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d13x  <= sub_ext(i_data.first_start_x, i_data.second_start_x);
            r_d13y  <= sub_ext(i_data.first_start_y, i_data.second_start_y);
            r_d12x  <= sub_ext(i_data.first_start_x, i_data.first_end_x);
            r_d12y  <= sub_ext(i_data.first_start_y, i_data.first_end_y);
            r_d34x  <= sub_ext(i_data.second_start_x, i_data.second_end_x);
            r_d34y  <= sub_ext(i_data.second_start_y, i_data.second_end_y);
            r1_dx21 <= sub_ext(i_data.first_end_x, i_data.first_start_x);
            r1_dy21 <= sub_ext(i_data.first_end_y, i_data.first_start_y);
            r1_bx   <= i_data.first_start_x;
            r1_by   <= i_data.first_start_y;

            r_m1    <= PROD_W'(r_d13x) * PROD_W'(r_d34y);
            r_m2    <= PROD_W'(r_d13y) * PROD_W'(r_d34x);
            r_m3    <= PROD_W'(r_d12x) * PROD_W'(r_d34y);
            r_m4    <= PROD_W'(r_d12y) * PROD_W'(r_d34x);
            r2_dx21 <= r1_dx21;
            r2_dy21 <= r1_dy21;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;

            r_num   <= CROSS_W'(r_m1) - CROSS_W'(r_m2);
            r3_den  <= CROSS_W'(r_m3) - CROSS_W'(r_m4);
            r3_dx21 <= r2_dx21;
            r3_dy21 <= r2_dy21;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;

            r_px    <= DIVIDEND_W'(r_num) * DIVIDEND_W'(r3_dx21);
            r_py    <= DIVIDEND_W'(r_num) * DIVIDEND_W'(r3_dy21);
            r4_den  <= r3_den;
            r4_bx   <= r3_bx;
            r4_by   <= r3_by;

            r_out.mag_x    <= r_px[DIVIDEND_W-1] ? DIVIDEND_W'(-r_px) : DIVIDEND_W'(r_px);
            r_out.mag_y    <= r_py[DIVIDEND_W-1] ? DIVIDEND_W'(-r_py) : DIVIDEND_W'(r_py);
            r_out.mag_den  <= r4_den[CROSS_W-1] ? CROSS_W'(-r4_den) : CROSS_W'(r4_den);
            r_out.neg_x    <= r_px[DIVIDEND_W-1] ^ r4_den[CROSS_W-1];
            r_out.neg_y    <= r_py[DIVIDEND_W-1] ^ r4_den[CROSS_W-1];
            r_out.den_zero <= (r4_den == '0);
            r_out.base_x   <= r4_bx;
            r_out.base_y   <= r4_by;
        end
    end

    assign o_data = r_out;

endmodule

@@ sv/lli_div.sv @@
// Pipelined restoring divider lane, one quotient bit per stage, with an
// up-front overflow check for quotients too large to keep. Uses lli_pkg.
module lli_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [lli_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [lli_pkg::CROSS_W-1:0]    i_divisor,
    output logic [lli_pkg::QUOT_W-1:0]     o_quot,
    output logic                           o_ovf
);
    import lli_pkg::*;

    localparam int CMP_W = DIVIDEND_W + 1;

    logic [DIVIDEND_W-1:0] r_rem [0:QUOT_W];
    logic [CROSS_W-1:0]    r_dm  [0:QUOT_W];
    logic [QUOT_W-1:0]     r_q   [0:QUOT_W];
    logic                  r_ovf [0:QUOT_W];

    // The kept quotient bits suffice exactly when dividend < divisor << QUOT_W.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_dividend;
            r_dm[0]  <= i_divisor;
            r_q[0]   <= '0;
            r_ovf[0] <= {1'b0, i_dividend} >= (CMP_W'(i_divisor) << QUOT_W);
        end
    end

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
        localparam int SH = QUOT_W - k;
        logic [CMP_W-1:0] trial;
        assign trial = {1'b0, r_rem[k-1]} - (CMP_W'(r_dm[k-1]) << SH);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= trial[CMP_W-1] ? r_rem[k-1] : trial[DIVIDEND_W-1:0];
                r_q[k]   <= r_q[k-1] | (QUOT_W'(!trial[CMP_W-1]) << SH);
                r_dm[k]  <= r_dm[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_q[QUOT_W];
    assign o_ovf  = r_ovf[QUOT_W];

endmodule

@@ sv/line_line_intersection_top.sv @@
// Intersection of two unbounded lines in Q12.4 fixed point.
// Depends on lli_pkg, lli_front and lli_div.
//
// Usage: the input channel (i_valid, o_stall, i_in) carries two lines, each
// as two points. The output channel (o_valid, i_stall, o_out) returns one
// result per input: found, the intersection point and a clipped flag. A
// transfer happens on a rising edge where valid is high and stall is low.
//
// The block is a pipeline of 25 register stages at the default
// coordinate width (five front-end stages, nineteen divider stages, one
// output stage). It accepts one transfer per cycle, sustained while the
// receiver does not stall; the throughput is set by the one-bit-per-stage
// divider lanes, which are fully pipelined.
//
// Parallel or degenerate lines give found = 0 and a zero point. A point
// outside the coordinate range saturates to the nearest limit and sets
// clipped.
//
// Reset clears all stage valid bits; items in flight are dropped. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises, so nothing is lost or repeated.
module line_line_intersection_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  lli_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output lli_pkg::t_out o_out
);
    import lli_pkg::*;

    localparam int LAT = FRONT_LAT + DIV_LAT + 1;

    logic   [LAT-1:0] r_vld;
    logic             en;
    t_front           front;
    t_side            r_side [0:DIV_LAT-1];
    logic [QUOT_W-1:0] quot_x, quot_y;
    logic             ovf_x, ovf_y;
    t_out             r_out;
    t_out             n_out;

    // The whole pipeline advances unless a finished result is held back.
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    lli_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_in),
        .o_data (front)
    );

    lli_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (front.mag_x),
        .i_divisor  (front.mag_den),
        .o_quot     (quot_x),
        .o_ovf      (ovf_x)
    );

    lli_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (front.mag_y),
        .i_divisor  (front.mag_den),
        .o_quot     (quot_y),
        .o_ovf      (ovf_y)
    );

    // Base point, signs and the parallel flag follow the divider lanes.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{neg_x: front.neg_x, neg_y: front.neg_y,
                           den_zero: front.den_zero,
                           base_x: front.base_x, base_y: front.base_y};
            for (int s = 1; s < DIV_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Applies the signed quotient to the base and saturates to the range.
    function automatic t_coord finish(input t_coord base, input logic [QUOT_W-1:0] q,
                                      input logic neg, input logic ovf,
                                      output logic clip);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lo_lim;
        logic signed [SUM_W-1:0] hi_lim;
        lo_lim = SUM_W'(signed'({1'b1, {(COORD_WIDTH-1){1'b0}}}));
        hi_lim = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
        sum    = neg ? SUM_W'(base) - SUM_W'({1'b0, q}) : SUM_W'(base) + SUM_W'({1'b0, q});
        clip   = 1'b1;
        if (ovf) begin
            finish = neg ? t_coord'(lo_lim) : t_coord'(hi_lim);
        end else if (sum < lo_lim) begin
            finish = t_coord'(lo_lim);
        end else if (sum > hi_lim) begin
            finish = t_coord'(hi_lim);
        end else begin
            finish = sum[COORD_WIDTH-1:0];
            clip   = 1'b0;
        end
    endfunction

    always_comb begin
        logic clip_x;
        logic clip_y;
        t_coord vx;
        t_coord vy;
        vx = finish(r_side[DIV_LAT-1].base_x, quot_x, r_side[DIV_LAT-1].neg_x, ovf_x, clip_x);
        vy = finish(r_side[DIV_LAT-1].base_y, quot_y, r_side[DIV_LAT-1].neg_y, ovf_y, clip_y);
        if (r_side[DIV_LAT-1].den_zero) begin
            n_out = '0;
        end else begin
            n_out.found   = 1'b1;
            n_out.cross_x = vx;
            n_out.cross_y = vy;
            n_out.clipped = clip_x | clip_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

@@ dv/tb_line_line_intersection_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the line intersection pipeline.
// Depends on lli_pkg and line_line_intersection_top, and through it on lli_front and lli_div.
module tb_line_line_intersection_top;
    import lli_pkg::*;

    localparam int PIPE_LAT = 25;
    localparam int MAX_ERR_SHOWN = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in i_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_out;

    // Expected results in the order their inputs transferred.
    t_out pending_points[$];
    int mismatch_count = 0;
    int result_count = 0;
    int sent_count = 0;
    int parallel_count = 0;
    int clipped_count = 0;
    // Receiver behavior: random stalls on or off, and a forced long hold-off.
    bit sink_random = 1'b0;
    int hold_cycles = 0;

    line_line_intersection_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in(i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out(o_out)
    );

    always #4 i_clk = ~i_clk;

    // Signed division truncating toward zero on 128-bit values; SystemVerilog
    // signed / already truncates toward zero, so the quotient is exact.
    function automatic t_coord solve_axis(input longint base, input longint delta,
                                          input logic signed [127:0] num,
                                          input logic signed [127:0] den,
                                          inout bit sat);
        logic signed [127:0] quot;
        logic signed [127:0] sum;
        begin
            quot = (num * delta) / den;
            sum = quot + base;
            if (sum < -32768) begin
                sat = 1'b1;
                return t_coord'(-32768);
            end
            if (sum > 32767) begin
                sat = 1'b1;
                return t_coord'(32767);
            end
            return t_coord'(sum[15:0]);
        end
    endfunction

    // Computes the intersection point that the block must return for one pair.
    function automatic t_out predict_crossing(input t_in lines);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] num, den;
        t_out res;
        bit sat;
        begin
            x1 = lines.first_start_x;  y1 = lines.first_start_y;
            x2 = lines.first_end_x;    y2 = lines.first_end_y;
            x3 = lines.second_start_x; y3 = lines.second_start_y;
            x4 = lines.second_end_x;   y4 = lines.second_end_y;
            num = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
            den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
            res = '0;
            sat = 1'b0;
            if (den != 0) begin
                res.found = 1'b1;
                res.cross_x = solve_axis(x1, x2 - x1, num, den, sat);
                res.cross_y = solve_axis(y1, y2 - y1, num, den, sat);
                res.clipped = sat;
            end
            return res;
        end
    endfunction

    // Mostly short gaps, occasionally a long one.
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55) return 0;
            if (r < 92) return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    // Offers one pair of lines and waits until the transfer completes.
    // Valid stays high straight into the next item when no gap follows.
    task automatic send_lines(input t_in lines, input bit with_gaps);
        int gap;
        begin
            gap = with_gaps ? pick_gap() : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in <= lines;
            i_valid <= 1'b1;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            pending_points.push_back(predict_crossing(lines));
            sent_count++;
        end
    endtask

    function automatic t_in make_lines(input int x1, y1, x2, y2, x3, y3, x4, y4);
        t_in l;
        begin
            l.first_start_x = t_coord'(x1);  l.first_start_y = t_coord'(y1);
            l.first_end_x = t_coord'(x2);    l.first_end_y = t_coord'(y2);
            l.second_start_x = t_coord'(x3); l.second_start_y = t_coord'(y3);
            l.second_end_x = t_coord'(x4);   l.second_end_y = t_coord'(y4);
            return l;
        end
    endfunction

    // Random coordinate biased toward the extremes and small values.
    function automatic t_coord rand_coord();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0) return t_coord'(16'h8000);
            if (r == 1) return t_coord'(16'h7fff);
            if (r < 5) return t_coord'($urandom_range(0, 511) - 256);
            return t_coord'($urandom);
        end
    endfunction

    // Random pair of lines; some are made parallel, degenerate or nearly parallel on purpose.
    function automatic t_in rand_lines();
        t_in l;
        int r;
        begin
            l = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            r = $urandom_range(0, 19);
            if (r == 0) begin
                l.first_end_x = l.first_start_x;
                l.first_end_y = l.first_start_y;
            end else if (r == 1) begin
                // Second line is a shifted copy of the first, so it is parallel.
                l.second_end_x = l.second_start_x + (l.first_end_x - l.first_start_x);
                l.second_end_y = l.second_start_y + (l.first_end_y - l.first_start_y);
            end else if (r == 2) begin
                // Nearly parallel lines push the crossing far away, though still inside the range.
                l.first_start_x = t_coord'(0); l.first_start_y = t_coord'(0);
                l.first_end_x = t_coord'(1000); l.first_end_y = t_coord'(1);
                l.second_start_x = t_coord'(0); l.second_start_y = t_coord'(16);
                l.second_end_x = t_coord'(1000); l.second_end_y = t_coord'(18);
            end
            return l;
        end
    endfunction

    // Drops valid and waits until every expected result has come back.
    task automatic wait_drained();
        begin
            i_valid <= 1'b0;
            while (pending_points.size() != 0) @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls when enabled, now and then a long hold-off,
    // and a forced hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (sink_random) begin
            if ($urandom_range(0, 99) < 2) begin
                hold_cycles <= $urandom_range(8, 40);
            end
            i_stall <= ($urandom_range(0, 99) < 30);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: every output transfer is matched with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (pending_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_ERR_SHOWN)
                    $display("unexpected result %p", o_out);
            end else begin
                want = pending_points.pop_front();
                if (!want.found) parallel_count++;
                if (want.clipped) clipped_count++;
                if (o_out.found !== want.found || o_out.cross_x !== want.cross_x ||
                    o_out.cross_y !== want.cross_y || o_out.clipped !== want.clipped) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_ERR_SHOWN)
                        $display({"mismatch: expected found=%0b x=%0d y=%0d clipped=%0b, ",
                                  "got found=%0b x=%0d y=%0d clipped=%0b"},
                                 want.found, want.cross_x, want.cross_y, want.clipped,
                                 o_out.found, o_out.cross_x, o_out.cross_y,
                                 o_out.clipped);
                end
            end
        end
    end

    // Corners, extremes, parallel and degenerate lines, and far crossings.
    task automatic test_directed();
        begin
            send_lines(make_lines(0, 0, 16, 16, 0, 16, 16, 0), 0);           // X crossing
            send_lines(make_lines(0, 0, 16, 0, 0, 16, 16, 16), 0);           // parallel
            send_lines(make_lines(0, 0, 16, 0, 32, 0, 48, 0), 0);            // coincident
            send_lines(make_lines(5, 5, 5, 5, 0, 16, 16, 0), 0);             // degenerate
            send_lines(make_lines(0, 0, 0, 0, 0, 0, 0, 0), 0);
            send_lines(make_lines(-1, -1, -1, -1, -1, -1, -1, -1), 0);
            send_lines(make_lines(-32768, -32768, 32767, 32767,
                                  -32768, 32767, 32767, -32768), 0);
            send_lines(make_lines(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 0);
            send_lines(make_lines(32767, 32767, -32768, -32768,
                                  32767, -32768, -32768, 32767), 0);
            send_lines(make_lines(0, 0, 1000, 1, 0, 16, 1000, 18), 0);       // far
            send_lines(make_lines(0, 0, 1000, -1, 0, -16, 1000, -18), 0);    // far, mirrored in y
            send_lines(make_lines(0, 0, 3, 1, 0, 1, 3, 0), 0);               // truncation
            send_lines(make_lines(0, 0, -3, 1, 0, 1, -3, 0), 0);
            send_lines(make_lines(100, 0, 101, 0, 0, 100, 0, 101), 0);       // beyond segment
            send_lines(make_lines(-32768, -32768, -32767, -32768,
                                  32767, 32767, 32767, 32766), 0);
            send_lines(make_lines(32767, -32768, -32768, 32767, 0, 0, 1, 1), 0);
            wait_drained();
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_streaming(input int count);
        begin
            repeat (count) send_lines(rand_lines(), 0);
            wait_drained();
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills.
    task automatic test_backpressure(input int count);
        begin
            @(posedge i_clk);
            hold_cycles <= 3 * PIPE_LAT + 20;
            repeat (count) send_lines(rand_lines(), 0);
            wait_drained();
        end
    endtask

    // Random gaps on both sides.
    task automatic test_random(input int count);
        begin
            sink_random = 1'b1;
            repeat (count) send_lines(rand_lines(), 1);
            wait_drained();
            sink_random = 1'b0;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_streaming(200);
        test_backpressure(150);
        test_random(1280);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        $display("Sent %0d line pairs, checked %0d results (%0d parallel, %0d clipped).",
                 sent_count, result_count, parallel_count, clipped_count);
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_points.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timed out with %0d results outstanding.", pending_points.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
